// File: rtl/core/stsc_pkg.sv
// ----------------------------------------------------------------------------
// Source token scanner package
// Token kinds, error codes, the token beat type, and the keyword and
// punctuation tables shared by the scanner modules.
// ----------------------------------------------------------------------------
package stsc_pkg;

    localparam int POS_BITS_DEF      = 24;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int KW_MAX_CHARS      = 8;
    localparam int KW_COUNT          = 15;
    localparam int MAX_TOKENS        = 3;
    localparam int FIFO_DEPTH        = 4;

    localparam logic [23:0] FIELD_MAX = 24'hFFFFFF;

    typedef logic [5:0] kind_t;
    typedef logic [1:0] err_t;

    localparam kind_t K_LPAREN   = 6'd0;
    localparam kind_t K_RPAREN   = 6'd1;
    localparam kind_t K_LBRACE   = 6'd2;
    localparam kind_t K_RBRACE   = 6'd3;
    localparam kind_t K_SEMI     = 6'd4;
    localparam kind_t K_COLON    = 6'd5;
    localparam kind_t K_COMMA    = 6'd6;
    localparam kind_t K_DOT      = 6'd7;
    localparam kind_t K_MINUS    = 6'd8;
    localparam kind_t K_PLUS     = 6'd9;
    localparam kind_t K_SLASH    = 6'd10;
    localparam kind_t K_STAR     = 6'd11;
    localparam kind_t K_BANG     = 6'd12;
    localparam kind_t K_BANG_EQ  = 6'd13;
    localparam kind_t K_EQUAL    = 6'd14;
    localparam kind_t K_EQUAL_EQ = 6'd15;
    localparam kind_t K_GREATER  = 6'd16;
    localparam kind_t K_GREATER_EQ = 6'd17;
    localparam kind_t K_LESS     = 6'd18;
    localparam kind_t K_LESS_EQ  = 6'd19;
    localparam kind_t K_IDENT    = 6'd20;
    localparam kind_t K_STRING   = 6'd21;
    localparam kind_t K_NUMBER   = 6'd22;
    localparam kind_t K_AND      = 6'd23;
    localparam kind_t K_ERROR    = 6'd38;
    localparam kind_t K_EOF      = 6'd39;

    localparam err_t ERR_NONE   = 2'd0;
    localparam err_t ERR_CHAR   = 2'd1;
    localparam err_t ERR_STRING = 2'd2;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [23:0] line_number;
        err_t        error_code;
        logic        last_of_run;
    } token_t;

    // Keywords in kind order, written reversed so that the first character
    // lands in the low byte.
    localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        64'("dna"), 64'("ssalc"), 64'("esle"), 64'("eslaf"), 64'("nf"),
        64'("rof"), 64'("fi"), 64'("tel"), 64'("lin"), 64'("ro"),
        64'("nruter"), 64'("repus"), 64'("siht"), 64'("eurt"), 64'("elihw")
    };

    function automatic kind_t keyword_kind(input logic [8*KW_MAX_CHARS-1:0] word);
        kind_t k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (word == KW_TEXT[i]) begin
                k = K_AND + kind_t'(i);
            end
        end
        return k;
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            ".":     k = K_DOT;
            "-":     k = K_MINUS;
            "+":     k = K_PLUS;
            "/":     k = K_SLASH;
            "*":     k = K_STAR;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/stsc_lexer.sv
// ----------------------------------------------------------------------------
// Source token scanner lexer
// Scan state, offsets and line count, and the single-pass logic that turns
// one accepted byte into up to three tokens.
// ----------------------------------------------------------------------------
module stsc_lexer
    import stsc_pkg::*;
#(
    parameter int POS_BITS      = POS_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  ch,
    input  logic        end_of_source,
    output token_t      tok [MAX_TOKENS],
    output logic [1:0]  tok_count
);

    localparam int SW = POS_BITS + 1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [12:0] {
        M_IDLE    = 13'b0000000000001,
        M_SLASH   = 13'b0000000000010,
        M_COMMENT = 13'b0000000000100,
        M_BANG    = 13'b0000000001000,
        M_EQUAL   = 13'b0000000010000,
        M_LESS    = 13'b0000000100000,
        M_GREATER = 13'b0000001000000,
        M_WORD    = 13'b0000010000000,
        M_INT     = 13'b0000100000000,
        M_INT_DOT = 13'b0001000000000,
        M_FRAC    = 13'b0010000000000,
        M_STR     = 13'b0100000000000,
        M_ENDED   = 13'b1000000000000
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [7:0]          prefix_reg [KEYWORD_CHARS];
    logic [7:0]          prefix_next [KEYWORD_CHARS];
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [23:0]         line_reg, line_next;

    logic                is_letter, is_digit, ended;
    logic [POS_BITS-1:0] span;
    logic [8*KW_MAX_CHARS-1:0] word_text;
    kind_t               word_k, single_k, pair_k;
    token_t              fa, fb, x;
    logic                fa_v, fb_v, x_v, flush_en, redo, line_inc;
    logic [1:0]          count;

    function automatic logic [23:0] sat_field(input logic [SW-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'(FIELD_MAX)) ? FIELD_MAX : w[23:0];
    endfunction

    assign is_letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    assign is_digit  = ch >= "0" && ch <= "9";
    assign ended     = end_of_source || ch == CH_NUL;
    assign span      = pos_reg - start_reg;

    // Only the bytes inside the current word take part in the keyword match.
    always_comb begin
        word_text = '0;
        for (int j = 0; j < KEYWORD_CHARS; j++) begin
            if (span > POS_BITS'(j)) begin
                word_text[8*j +: 8] = prefix_reg[j];
            end
        end
        word_k = (span > POS_BITS'(KEYWORD_CHARS)) ? K_IDENT : keyword_kind(word_text);
    end

    always_comb begin
        case (mode_reg)
            M_BANG: begin
                single_k = K_BANG;
                pair_k   = K_BANG_EQ;
            end
            M_EQUAL: begin
                single_k = K_EQUAL;
                pair_k   = K_EQUAL_EQ;
            end
            M_GREATER: begin
                single_k = K_GREATER;
                pair_k   = K_GREATER_EQ;
            end
            default: begin
                single_k = K_LESS;
                pair_k   = K_LESS_EQ;
            end
        endcase
    end

    // Tokens left pending by the current mode when the next byte cannot extend it.
    always_comb begin
        fa = '{kind: K_ERROR, start_offset: sat_field(SW'(start_reg)), token_length: 24'd1,
               line_number: line_reg, error_code: ERR_NONE, last_of_run: 1'b0};
        fb = '{kind: K_DOT, start_offset: sat_field(SW'((pos_reg != '0) ? pos_reg - 1'b1 : '0)),
               token_length: 24'd1, line_number: line_reg, error_code: ERR_NONE,
               last_of_run: 1'b0};
        fa_v = 1'b0;
        fb_v = 1'b0;
        case (mode_reg)
            M_SLASH: begin
                fa_v    = 1'b1;
                fa.kind = K_SLASH;
            end
            M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                fa_v    = 1'b1;
                fa.kind = single_k;
            end
            M_WORD: begin
                fa_v            = 1'b1;
                fa.kind         = word_k;
                fa.token_length = sat_field(SW'(span));
            end
            M_INT, M_FRAC: begin
                fa_v            = 1'b1;
                fa.kind         = K_NUMBER;
                fa.token_length = sat_field(SW'(span));
            end
            M_INT_DOT: begin
                fa_v            = 1'b1;
                fb_v            = 1'b1;
                fa.kind         = K_NUMBER;
                fa.token_length = sat_field(SW'((span != '0) ? span - 1'b1 : '0));
            end
            M_STR: begin
                fa_v            = 1'b1;
                fa.kind         = K_ERROR;
                fa.token_length = sat_field(SW'(span));
                fa.error_code   = ERR_STRING;
            end
            default: begin
                fa_v = 1'b0;
            end
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        redo        = 1'b0;
        flush_en    = 1'b0;
        line_inc    = 1'b0;
        x_v         = 1'b0;
        x = '{kind: K_EOF, start_offset: sat_field(SW'(pos_reg)), token_length: 24'd0,
              line_number: line_reg, error_code: ERR_NONE, last_of_run: 1'b0};

        if (mode_reg == M_ENDED) begin
            x_v = 1'b1;
        end else if (ended) begin
            flush_en  = 1'b1;
            x_v       = 1'b1;
            mode_next = M_ENDED;
        end else begin
            case (mode_reg)
                M_SLASH: begin
                    if (ch == "/") begin
                        mode_next = M_COMMENT;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (ch == CH_LF) begin
                        line_inc  = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                    if (ch == "=") begin
                        x_v            = 1'b1;
                        x.kind         = pair_k;
                        x.start_offset = sat_field(SW'(start_reg));
                        x.token_length = sat_field(SW'(span) + 1'b1);
                        mode_next      = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_letter || is_digit) begin
                        for (int j = 0; j < KEYWORD_CHARS; j++) begin
                            if (span == POS_BITS'(j)) begin
                                prefix_next[j] = ch;
                            end
                        end
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_INT: begin
                    if (ch == ".") begin
                        mode_next = M_INT_DOT;
                    end else if (!is_digit) begin
                        redo = 1'b1;
                    end
                end
                M_INT_DOT: begin
                    if (is_digit) begin
                        mode_next = M_FRAC;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit) begin
                        redo = 1'b1;
                    end
                end
                M_STR: begin
                    if (ch == "\"") begin
                        x_v            = 1'b1;
                        x.kind         = K_STRING;
                        x.start_offset = sat_field(SW'(start_reg));
                        x.token_length = sat_field(SW'(span) + 1'b1);
                        mode_next      = M_IDLE;
                    end else if (ch == CH_LF) begin
                        line_inc = 1'b1;
                    end
                end
                default: begin
                    redo = 1'b1;
                end
            endcase

            if (redo) begin
                flush_en   = 1'b1;
                mode_next  = M_IDLE;
                start_next = pos_reg;
                if (ch == CH_LF) begin
                    line_inc = 1'b1;
                end else if (is_letter) begin
                    for (int j = 0; j < KEYWORD_CHARS; j++) begin
                        prefix_next[j] = 8'd0;
                    end
                    prefix_next[0] = ch;
                    mode_next      = M_WORD;
                end else if (is_digit) begin
                    mode_next = M_INT;
                end else if (ch == "/") begin
                    mode_next = M_SLASH;
                end else if (ch == "!") begin
                    mode_next = M_BANG;
                end else if (ch == "=") begin
                    mode_next = M_EQUAL;
                end else if (ch == "<") begin
                    mode_next = M_LESS;
                end else if (ch == ">") begin
                    mode_next = M_GREATER;
                end else if (ch == "\"") begin
                    mode_next = M_STR;
                end else if (ch != CH_SPACE && ch != CH_CR && ch != CH_TAB) begin
                    x_v            = 1'b1;
                    x.kind         = punct_kind(ch);
                    x.token_length = 24'd1;
                    x.error_code   = (x.kind == K_ERROR) ? ERR_CHAR : ERR_NONE;
                end
            end

            if (pos_reg != '1) begin
                pos_next = pos_reg + 1'b1;
            end
        end

        if (line_inc && line_reg != FIELD_MAX) begin
            line_next = line_reg + 1'b1;
        end
    end

    // Pack the pending tokens and the closing token into consecutive slots.
    always_comb begin
        tok[0] = x;
        tok[1] = x;
        tok[2] = x;
        if (flush_en && fa_v && fb_v) begin
            tok[0] = fa;
            tok[1] = fb;
            count  = 2'd2 + 2'(x_v);
        end else if (flush_en && fa_v) begin
            tok[0] = fa;
            count  = 2'd1 + 2'(x_v);
        end else begin
            count  = 2'(x_v);
        end
        for (int k = 0; k < MAX_TOKENS; k++) begin
            tok[k].last_of_run = (count == 2'(k + 1));
        end
    end

    assign tok_count = count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= 24'd1;
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                prefix_reg[j] <= 8'd0;
            end
        end else if (step) begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
        end
    end

`ifndef ASSERT_OFF
    a_ended_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == M_ENDED) |=> (mode_reg == M_ENDED))
        else $error("Scanner left the ended state without a reset.");

    a_ended_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mode_reg == M_ENDED) |-> (tok_count == 2'd1))
        else $error("An input after end of source did not give exactly one token.");

    a_token_start_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_reg <= pos_reg))
        else $error("Token start offset is past the current position.");
`endif

endmodule

// File: rtl/core/stsc_token_fifo.sv
// ----------------------------------------------------------------------------
// Source token scanner token queue
// Small register queue that takes up to three tokens per cycle from the
// lexer and presents one token beat per cycle while the result side is ready.
// ----------------------------------------------------------------------------
module stsc_token_fifo
    import stsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  push_count,
    input  token_t      push_data [MAX_TOKENS],
    output logic        room,
    input  logic        pop_ready,
    output logic        out_valid,
    output token_t      out_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    token_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;
    assign room      = count_reg <= CNT_W'(FIFO_DEPTH - MAX_TOKENS);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_TOKENS; k++) begin
            if (2'(k) < push_count) begin
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_data[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_W'(FIFO_DEPTH)))
        else $error("Token queue holds more entries than its depth.");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> room)
        else $error("Tokens were pushed without room for a full run.");
`endif

endmodule

// File: rtl/core/source_token_scanner.sv
// ----------------------------------------------------------------------------
// Source token scanner
// Byte-stream lexer that emits punctuation, operators, identifiers,
// keywords, numbers, strings, errors and end-of-input tokens.
// ----------------------------------------------------------------------------
// The scanner accepts one source byte per cycle whenever its four-entry token
// queue holds at most one token, and its state (mode, word prefix, offsets and
// line count) is updated in the same cycle; the tokens a byte produces are
// written into the token queue when the byte is accepted. A byte produces
// zero to three tokens and the result port delivers one token beat per cycle
// while the result side is ready, so bytes that yield at most one token each
// stream at one byte per cycle under that condition. A byte that leaves two
// or more tokens queued holds the input off until the queue drains back to
// one token. No byte is accepted during reset. After end of source every
// further byte yields another end-of-input token until reset.
module source_token_scanner
    import stsc_pkg::*;
#(
    parameter int POS_BITS      = POS_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_kind,
    output logic [23:0] m_start_offset,
    output logic [23:0] m_token_length,
    output logic [23:0] m_line_number,
    output logic [1:0]  m_error_code,
    output logic        m_last_of_run
);

    logic       step;
    logic       room;
    token_t     tok [MAX_TOKENS];
    logic [1:0] tok_count;
    logic [1:0] push_count;
    token_t     out_tok;

    assign s_ready    = room && aresetn;
    assign step       = s_valid && s_ready;
    assign push_count = step ? tok_count : 2'd0;

    stsc_lexer #(
        .POS_BITS      (POS_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_lexer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .ch            (s_ch),
        .end_of_source (s_end_of_source),
        .tok           (tok),
        .tok_count     (tok_count)
    );

    stsc_token_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_data  (tok),
        .room       (room),
        .pop_ready  (m_ready),
        .out_valid  (m_valid),
        .out_data   (out_tok)
    );

    assign m_kind         = out_tok.kind;
    assign m_start_offset = out_tok.start_offset;
    assign m_token_length = out_tok.token_length;
    assign m_line_number  = out_tok.line_number;
    assign m_error_code   = out_tok.error_code;
    assign m_last_of_run  = out_tok.last_of_run;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Source token scanner testbench
// Drives source bytes through the scanner and checks every token beat against
// a behavioral lexer that runs alongside the stimulus or, for directed rows
// that carry their own token, against that token. A short table of directed
// bytes covers the extremes, operators, comments, strings and errors. It is
// followed by random lexemes with random content, and a tail that ends the
// source and keeps feeding bytes after the end. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stsc_pkg::*;

    typedef enum logic [3:0] {
        SM_IDLE, SM_SLASH, SM_COMMENT, SM_BANG, SM_EQUAL, SM_LESS, SM_GREATER,
        SM_WORD, SM_INT, SM_INT_DOT, SM_FRAC, SM_STR, SM_ENDED
    } scan_mode_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        token_t     tok;
    } stim_row_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] BLANKS [4] = '{8'h20, CH_TAB, CH_CR, CH_LF};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = 8'h00;
    logic        s_end_of_source = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_kind;
    logic [23:0] m_start_offset;
    logic [23:0] m_token_length;
    logic [23:0] m_line_number;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    string kw_words [KW_COUNT] = '{
        "and", "class", "else", "false", "fn", "for", "if", "let", "nil", "or",
        "return", "super", "this", "true", "while"
    };
    string punct_text = "(){};:,.-+/*";
    string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string op_chars = "!=<>/(){};:,.-+*";

    scan_mode_e  sm = SM_IDLE;
    logic [7:0]  word_head [KEYWORD_CHARS_DEF] = '{default: 8'h00};
    logic [23:0] tok_at = '0;
    logic [23:0] cur_pos = '0;
    logic [23:0] line_cnt = 24'd1;

    token_t      byte_tokens [$];
    token_t      tokens_due [$];
    logic [7:0]  lexeme [$];
    int unsigned mismatch_cnt = 0;
    int          burst_left = 0;
    int          ready_style = 0;
    int          ready_span = 0;

    stim_row_t directed_rows [25] = '{
        '{"(",      1'b0, 1'b1, '{K_LPAREN, 24'd0, 24'd1, 24'd1, ERR_NONE, 1'b1}},
        '{8'hFF,    1'b0, 1'b1, '{K_ERROR, 24'd1, 24'd1, 24'd1, ERR_CHAR, 1'b1}},
        '{8'h80,    1'b0, 1'b1, '{K_ERROR, 24'd2, 24'd1, 24'd1, ERR_CHAR, 1'b1}},
        '{"1",      1'b0, 1'b0, '0},
        '{".",      1'b0, 1'b0, '0},
        '{"+",      1'b0, 1'b0, '0},
        '{"!",      1'b0, 1'b0, '0},
        '{"=",      1'b0, 1'b1, '{K_BANG_EQ, 24'd6, 24'd2, 24'd1, ERR_NONE, 1'b1}},
        '{"<",      1'b0, 1'b0, '0},
        '{"<",      1'b0, 1'b0, '0},
        '{"=",      1'b0, 1'b0, '0},
        '{"/",      1'b0, 1'b0, '0},
        '{"/",      1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},
        '{"f",      1'b0, 1'b0, '0},
        '{"n",      1'b0, 1'b0, '0},
        '{" ",      1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{">",      1'b0, 1'b0, '0},
        '{"2",      1'b0, 1'b0, '0},
        '{".",      1'b0, 1'b0, '0},
        '{"5",      1'b0, 1'b0, '0},
        '{"*",      1'b0, 1'b0, '0}
    };

    source_token_scanner i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_end_of_source (s_end_of_source),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_start_offset  (m_start_offset),
        .m_token_length  (m_token_length),
        .m_line_number   (m_line_number),
        .m_error_code    (m_error_code),
        .m_last_of_run   (m_last_of_run)
    );

    always #1ns aclk = ~aclk;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [23:0] sat24(input logic [24:0] v);
        return (v > {1'b0, FIELD_MAX}) ? FIELD_MAX : v[23:0];
    endfunction

    function automatic void bump_line();
        if (line_cnt != FIELD_MAX) begin
            line_cnt = line_cnt + 24'd1;
        end
    endfunction

    function automatic void add_token(input kind_t k, input logic [23:0] at,
                                      input logic [24:0] len, input err_t err);
        token_t t;
        if (byte_tokens.size() < MAX_TOKENS) begin
            t.kind         = k;
            t.start_offset = at;
            t.token_length = sat24(len);
            t.line_number  = line_cnt;
            t.error_code   = err;
            t.last_of_run  = 1'b0;
            byte_tokens.push_back(t);
        end
    endfunction

    function automatic kind_t op_kind(input scan_mode_e m);
        case (m)
            SM_BANG:    return K_BANG;
            SM_EQUAL:   return K_EQUAL;
            SM_GREATER: return K_GREATER;
            default:    return K_LESS;
        endcase
    endfunction

    function automatic kind_t word_kind(input logic [23:0] len);
        logic hit;
        if (len > 24'(KEYWORD_CHARS_DEF)) begin
            return K_IDENT;
        end
        for (int i = 0; i < KW_COUNT; i++) begin
            if (24'(kw_words[i].len()) == len) begin
                hit = 1'b1;
                for (int j = 0; j < kw_words[i].len(); j++) begin
                    if (word_head[j] != kw_words[i][j]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    return K_AND + kind_t'(i);
                end
            end
        end
        return K_IDENT;
    endfunction

    // Emits whatever tokens are pending when the next byte cannot extend them.
    function automatic void flush_pending(input logic [23:0] at);
        logic [23:0] n;
        n = at - tok_at;
        case (sm)
            SM_SLASH: add_token(K_SLASH, tok_at, 25'd1, ERR_NONE);
            SM_BANG, SM_EQUAL, SM_LESS, SM_GREATER: add_token(op_kind(sm), tok_at, 25'd1, ERR_NONE);
            SM_WORD: add_token(word_kind(n), tok_at, {1'b0, n}, ERR_NONE);
            SM_INT, SM_FRAC: add_token(K_NUMBER, tok_at, {1'b0, n}, ERR_NONE);
            SM_INT_DOT: begin
                add_token(K_NUMBER, tok_at, (at > tok_at) ? {1'b0, n - 24'd1} : 25'd0, ERR_NONE);
                add_token(K_DOT, (at > 24'd0) ? at - 24'd1 : 24'd0, 25'd1, ERR_NONE);
            end
            SM_STR: add_token(K_ERROR, tok_at, {1'b0, n}, ERR_STRING);
            default: ;
        endcase
        sm = SM_IDLE;
    endfunction

    function automatic void start_at(input logic [7:0] c, input logic [23:0] p);
        tok_at = p;
        if (c == " " || c == CH_CR || c == CH_TAB) begin
            return;
        end
        if (c == CH_LF) begin
            bump_line();
            return;
        end
        if (is_alpha(c)) begin
            foreach (word_head[i]) word_head[i] = 8'h00;
            word_head[0] = c;
            sm = SM_WORD;
            return;
        end
        if (is_digit(c)) begin
            sm = SM_INT;
            return;
        end
        case (c)
            "/":      sm = SM_SLASH;
            "!":      sm = SM_BANG;
            "=":      sm = SM_EQUAL;
            "<":      sm = SM_LESS;
            ">":      sm = SM_GREATER;
            CH_QUOTE: sm = SM_STR;
            default: begin
                for (int i = 0; i < punct_text.len(); i++) begin
                    if (punct_text[i] == c) begin
                        add_token(kind_t'(i), p, 25'd1, ERR_NONE);
                        return;
                    end
                end
                add_token(K_ERROR, p, 25'd1, ERR_CHAR);
            end
        endcase
    endfunction

    // Advances the lexer by one accepted beat and leaves its tokens in byte_tokens.
    function automatic void lex_byte(input logic [7:0] c, input logic eos);
        logic [23:0] p;
        logic        redo;
        byte_tokens.delete();
        p = cur_pos;
        redo = 1'b0;
        if (sm == SM_ENDED) begin
            add_token(K_EOF, p, 25'd0, ERR_NONE);
        end else if (eos || c == CH_NUL) begin
            flush_pending(p);
            add_token(K_EOF, p, 25'd0, ERR_NONE);
            sm = SM_ENDED;
        end else begin
            case (sm)
                SM_SLASH: begin
                    if (c == "/") sm = SM_COMMENT;
                    else redo = 1'b1;
                end
                SM_COMMENT: begin
                    if (c == CH_LF) begin
                        bump_line();
                        sm = SM_IDLE;
                    end
                end
                SM_BANG, SM_EQUAL, SM_LESS, SM_GREATER: begin
                    if (c == "=") begin
                        add_token(op_kind(sm) + 6'd1, tok_at, {1'b0, p - tok_at} + 25'd1,
                                  ERR_NONE);
                        sm = SM_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                SM_WORD: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (p - tok_at < 24'(KEYWORD_CHARS_DEF)) word_head[3'(p - tok_at)] = c;
                    end else begin
                        redo = 1'b1;
                    end
                end
                SM_INT: begin
                    if (c == ".") sm = SM_INT_DOT;
                    else if (!is_digit(c)) redo = 1'b1;
                end
                SM_INT_DOT: begin
                    if (is_digit(c)) sm = SM_FRAC;
                    else redo = 1'b1;
                end
                SM_FRAC: begin
                    if (!is_digit(c)) redo = 1'b1;
                end
                SM_STR: begin
                    if (c == CH_QUOTE) begin
                        add_token(K_STRING, tok_at, {1'b0, p - tok_at} + 25'd1, ERR_NONE);
                        sm = SM_IDLE;
                    end else if (c == CH_LF) begin
                        bump_line();
                    end
                end
                default: redo = 1'b1;
            endcase
            if (redo) begin
                flush_pending(p);
                start_at(c, p);
            end
            if (cur_pos != FIELD_MAX) cur_pos = cur_pos + 24'd1;
        end
        if (byte_tokens.size() > 0) begin
            byte_tokens[byte_tokens.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    // Fills lexeme with one random source fragment and returns its length.
    function automatic int build_lexeme();
        int          pick;
        int          n;
        int          w;
        logic [7:0]  b;
        lexeme.delete();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            w = $urandom_range(0, KW_COUNT - 1);
            for (int i = 0; i < kw_words[w].len(); i++) lexeme.push_back(kw_words[w][i]);
            case ($urandom_range(0, 3))
                0: void'(lexeme.pop_back());
                1: lexeme.push_back(ident_chars[$urandom_range(0, 62)]);
                default: ;
            endcase
        end else if (pick < 30) begin
            lexeme.push_back(ident_chars[$urandom_range(0, 52)]);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
            repeat (n) lexeme.push_back(ident_chars[$urandom_range(0, 62)]);
        end else if (pick < 45) begin
            repeat ($urandom_range(1, 5)) lexeme.push_back(8'("0" + $urandom_range(0, 9)));
            w = $urandom_range(0, 2);
            if (w > 0) lexeme.push_back(".");
            if (w == 2) begin
                repeat ($urandom_range(1, 3)) lexeme.push_back(8'("0" + $urandom_range(0, 9)));
            end
        end else if (pick < 55) begin
            lexeme.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 8)) begin
                b = 8'($urandom_range(1, 255));
                lexeme.push_back((b == CH_QUOTE) ? CH_LF : b);
            end
            lexeme.push_back(CH_QUOTE);
        end else if (pick < 70) begin
            if ($urandom_range(0, 1) == 1) begin
                lexeme.push_back(op_chars[$urandom_range(0, 3)]);
                lexeme.push_back("=");
            end else begin
                lexeme.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
            end
        end else if (pick < 78) begin
            lexeme.push_back("/");
            lexeme.push_back("/");
            repeat ($urandom_range(0, 10)) begin
                b = 8'($urandom_range(1, 255));
                lexeme.push_back((b == CH_LF) ? 8'h20 : b);
            end
            lexeme.push_back(CH_LF);
        end else if (pick < 90) begin
            lexeme.push_back(BLANKS[$urandom_range(0, 3)]);
        end else begin
            repeat ($urandom_range(1, 3)) lexeme.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 9) < 6) lexeme.push_back(BLANKS[$urandom_range(0, 3)]);
        return lexeme.size();
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eos, input logic typed,
                             input token_t tok);
        int gap;
        s_valid <= 1'b1;
        s_ch <= c;
        s_end_of_source <= eos;
        do @(posedge aclk); while (!s_ready);
        lex_byte(c, eos);
        if (typed) begin
            tokens_due.push_back(tok);
        end else begin
            foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic report_token(input string what, input token_t want, input token_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%s: expected kind %0d start %0d len %0d line %0d err %0d last %0d",
                     what, want.kind, want.start_offset, want.token_length,
                     want.line_number, want.error_code, want.last_of_run);
            $display("    got kind %0d start %0d len %0d line %0d err %0d last %0d",
                     got.kind, got.start_offset, got.token_length, got.line_number,
                     got.error_code, got.last_of_run);
        end
    endtask

    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_style <= $urandom_range(0, 3);
            ready_span <= $urandom_range(8, 80);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin : check_tokens
        token_t got;
        token_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_start_offset, m_token_length, m_line_number, m_error_code,
                   m_last_of_run};
            if (tokens_due.size() == 0) begin
                report_token("token beat with nothing expected", '0, got);
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) report_token("token mismatch", want, got);
            end
        end
    end

    initial begin : stimulus
        int counted;
        counted = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].typed,
                      directed_rows[i].tok);
        end
        while (counted < 400) begin
            counted += build_lexeme();
            foreach (lexeme[i]) send_byte(lexeme[i], 1'b0, 1'b0, '0);
        end
        if (sm == SM_STR) send_byte(CH_QUOTE, 1'b0, 1'b0, '0);
        send_byte(CH_LF, 1'b0, 1'b0, '0);
        send_byte(CH_QUOTE, 1'b0, 1'b0, '0);
        send_byte("a", 1'b0, 1'b0, '0);
        send_byte(CH_LF, 1'b0, 1'b0, '0);
        send_byte(CH_NUL, 1'b0, 1'b0, '0);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        s_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: source_token_scanner.f
rtl/core/stsc_pkg.sv
rtl/core/stsc_lexer.sv
rtl/core/stsc_token_fifo.sv
rtl/core/source_token_scanner.sv
tb/tb_top.sv
